// File: hdl/bpfa_pkg.sv
// shared constants, codes and types of the bitmap page frame allocator
package bpfa_pkg;

  localparam int MAP_PAGES   = 4096;
  localparam int MAX_REGIONS = 3;
  localparam int PAGE_BYTES  = 4096;

  localparam int NUM_REGIONS = 3;
  localparam int WORD_BITS   = 64;
  localparam int MAP_WORDS   = MAP_PAGES / WORD_BITS;
  localparam int WORD_AW     = $clog2(MAP_WORDS);
  localparam int BIT_AW      = $clog2(WORD_BITS);
  localparam int PAGE_AW     = 12;
  localparam int PAGE_SHIFT  = $clog2(PAGE_BYTES);
  localparam int PAGES_W     = 13;
  localparam int SUM_W       = PAGES_W + 2;
  localparam int TOTAL_W     = $clog2(MAP_PAGES + 1);
  localparam int ADDR_W      = 64;
  localparam int CFG_AW      = 6;
  localparam int CFG_DW      = 64;

  typedef enum logic [1:0] {
    MODE_ALLOC     = 2'd0,
    MODE_MARK_USED = 2'd1,
    MODE_MARK_FREE = 2'd2,
    MODE_NONE      = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    STS_OK    = 2'd0,
    STS_OOM   = 2'd1,
    STS_RANGE = 2'd2
  } sts_t;

  typedef enum logic [2:0] {
    REG_COUNT  = 3'd0,
    REG_BASE0  = 3'd1,
    REG_PAGES0 = 3'd2,
    REG_BASE1  = 3'd3,
    REG_PAGES1 = 3'd4,
    REG_BASE2  = 3'd5,
    REG_PAGES2 = 3'd6
  } cfg_reg_t;

endpackage

// File: hdl/bpfa_if.sv
// request and result channel interfaces of the bitmap page frame allocator
interface bpfa_req_if import bpfa_pkg::*;;
  logic               valid;
  logic               ready;
  logic [1:0]         mode;
  logic [PAGE_AW-1:0] page_index;

  modport source (output valid, output mode, output page_index, input ready);
  modport sink (input valid, input mode, input page_index, output ready);
endinterface

interface bpfa_rsp_if import bpfa_pkg::*;;
  logic              valid;
  logic              ready;
  logic [ADDR_W-1:0] address;
  logic [1:0]        status;

  modport source (output valid, output address, output status, input ready);
  modport sink (input valid, input address, input status, output ready);
endinterface

// File: hdl/bitmap_page_frame_allocator.sv
// bitmap page frame allocator: one used/free bit per page, up to three regions
//
// The block keeps one used/free bit for each of 4096 pages in a 64 x 64-bit
// bitmap memory (one synchronous read port, read data in the next cycle); every
// page is free after reset, which per-word valid flags give at once, so no
// clearing pass is needed. The regions lie end to end in one global page
// numbering, region 0 first; the page total is the sum of the page counts of
// the regions in use, saturated at 4096. An allocate request takes the lowest
// free page below the total, marks it used and returns base + offset * 4096 of
// the region that holds it (status out of memory and address 0 when none is
// free). Mark requests set or clear one page's bit (status out of range when
// the index is not below the total). Mode 3 returns status ok and changes
// nothing. Configuration goes through the APB port at byte address 8 * index;
// the user must configure only while no request is in flight, which the block
// itself does not enforce; the bitmap keeps its bits across reconfiguration.
// Requests are handled one at a time: the next is taken only once the last
// result is in the output register. An allocate scans from word 0, reading one
// bitmap word per cycle through the memory's single read port, then finds the
// region and adds the offset; a mark request reads, modifies and writes back.
// The result waits in an output register, so a stalled result channel does not
// hold the next acceptance.
module bitmap_page_frame_allocator import bpfa_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  bpfa_req_if.sink          in_req,
  bpfa_rsp_if.source        out_rsp,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [CFG_AW-1:0] cfg_paddr,
  input  logic [CFG_DW-1:0] cfg_pwdata,
  output logic [CFG_DW-1:0] cfg_prdata,
  output logic              cfg_pready
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_MARK,
    ST_WALK,
    ST_ADD,
    ST_DONE
  } state_t;

  // configuration registers
  logic [1:0]         region_cnt_r;
  logic [ADDR_W-1:0]  base_r  [NUM_REGIONS];
  logic [PAGES_W-1:0] pages_r [NUM_REGIONS];

  cfg_reg_t cfg_idx;
  logic     cfg_wr;

  // request control and datapath
  state_t             state_r;
  mode_t              mode_r;
  logic [PAGE_AW-1:0] page_r;
  logic [WORD_AW-1:0] chk_w_r;
  logic [1:0]         sel_r;
  logic               hit_r;
  logic [PAGE_AW-1:0] rem_r;
  logic [ADDR_W-1:0]  res_addr_r;
  sts_t               res_sts_r;
  logic               out_vld_r;
  logic [ADDR_W-1:0]  out_addr_r;
  sts_t               out_sts_r;

  // bitmap memory
  logic [WORD_BITS-1:0] map_mem [MAP_WORDS];
  logic [WORD_BITS-1:0] mem_q_r;
  logic                 rd_vld_r;
  logic [MAP_WORDS-1:0] word_vld_r;
  logic                 rd_en;
  logic [WORD_AW-1:0]   rd_addr;
  logic                 wr_en;
  logic [WORD_AW-1:0]   wr_addr;
  logic [WORD_BITS-1:0] wr_data;
  logic [WORD_BITS-1:0] word_q;

  // derived values
  logic [1:0]           n_use;
  logic [SUM_W-1:0]     page_sum;
  logic [TOTAL_W-1:0]   total_w;
  logic                 in_acc;
  mode_t                in_mode;
  logic                 in_range;
  logic [TOTAL_W-1:0]   lim;
  logic [WORD_BITS-1:0] lim_mask;
  logic [WORD_BITS-1:0] free;
  logic [WORD_BITS-1:0] iso;
  logic [BIT_AW-1:0]    free_idx;
  logic                 any_free;
  logic [WORD_AW:0]     nxt_w_ext;
  logic                 more;
  logic [WORD_BITS-1:0] bit_oh;
  logic [WORD_BITS-1:0] mark_word;
  logic [PAGE_AW-1:0]   walk_rem;
  logic                 walk_hit;
  logic [1:0]           walk_sel;

  // ---------------------------------------------------------------------------
  // configuration port: 8-byte register slots, writes in the access phase
  // ---------------------------------------------------------------------------
  assign cfg_pready = 1'b1;
  assign cfg_idx    = cfg_reg_t'(cfg_paddr[CFG_AW-1:3]);
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      region_cnt_r <= '0;
      for (int r = 0; r < NUM_REGIONS; r++) begin
        base_r[r]  <= '0;
        pages_r[r] <= '0;
      end
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_COUNT:  region_cnt_r <= cfg_pwdata[1:0];
        REG_BASE0:  base_r[0]    <= cfg_pwdata;
        REG_PAGES0: pages_r[0]   <= cfg_pwdata[PAGES_W-1:0];
        REG_BASE1:  base_r[1]    <= cfg_pwdata;
        REG_PAGES1: pages_r[1]   <= cfg_pwdata[PAGES_W-1:0];
        REG_BASE2:  base_r[2]    <= cfg_pwdata;
        REG_PAGES2: pages_r[2]   <= cfg_pwdata[PAGES_W-1:0];
        default: ;  // slot beyond the register list
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_COUNT:  cfg_prdata = CFG_DW'(region_cnt_r);
      REG_BASE0:  cfg_prdata = base_r[0];
      REG_PAGES0: cfg_prdata = CFG_DW'(pages_r[0]);
      REG_BASE1:  cfg_prdata = base_r[1];
      REG_PAGES1: cfg_prdata = CFG_DW'(pages_r[1]);
      REG_BASE2:  cfg_prdata = base_r[2];
      REG_PAGES2: cfg_prdata = CFG_DW'(pages_r[2]);
      default:    cfg_prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // page total over the regions in use, saturated at the map size
  // ---------------------------------------------------------------------------
  assign n_use = (region_cnt_r > 2'(MAX_REGIONS)) ? 2'(MAX_REGIONS) : region_cnt_r;

  always_comb begin
    page_sum = '0;
    for (int r = 0; r < NUM_REGIONS; r++) begin
      if (2'(r) < n_use) page_sum = page_sum + SUM_W'(pages_r[r]);
    end
  end

  assign total_w = (page_sum > SUM_W'(MAP_PAGES)) ? TOTAL_W'(MAP_PAGES)
                                                  : page_sum[TOTAL_W-1:0];

  // ---------------------------------------------------------------------------
  // input side: one request at a time, taken only in idle
  // ---------------------------------------------------------------------------
  assign in_req.ready = (state_r == ST_IDLE);
  assign in_acc       = in_req.valid && in_req.ready;
  assign in_mode      = mode_t'(in_req.mode);
  assign in_range     = TOTAL_W'(in_req.page_index) < total_w;

  // ---------------------------------------------------------------------------
  // bitmap memory; a word never written reads as all free
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (wr_en) map_mem[wr_addr] <= wr_data;
    if (rd_en) begin
      mem_q_r  <= map_mem[rd_addr];
      rd_vld_r <= word_vld_r[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      word_vld_r <= '0;
    end else if (wr_en) begin
      word_vld_r[wr_addr] <= 1'b1;
    end
  end

  assign word_q = rd_vld_r ? mem_q_r : '0;

  // ---------------------------------------------------------------------------
  // scan: free pages of the checked word below the total, lowest one first
  // ---------------------------------------------------------------------------
  assign lim      = total_w - TOTAL_W'({chk_w_r, {BIT_AW{1'b0}}});
  assign lim_mask = (lim >= TOTAL_W'(WORD_BITS)) ? '1
                  : (WORD_BITS'(1) << lim[BIT_AW-1:0]) - WORD_BITS'(1);
  assign free     = ~word_q & lim_mask;
  assign iso      = free & (~free + WORD_BITS'(1));
  assign any_free = |free;

  always_comb begin
    free_idx = '0;
    for (int b = 0; b < WORD_BITS; b++) begin
      if (iso[b]) free_idx = free_idx | BIT_AW'(b);
    end
  end

  // next word is worth reading only if it starts below the total
  assign nxt_w_ext = {1'b0, chk_w_r} + (WORD_AW + 1)'(1);
  assign more      = TOTAL_W'({nxt_w_ext, {BIT_AW{1'b0}}}) < total_w;

  // mark: set or clear one bit of the read word
  assign bit_oh    = WORD_BITS'(1) << page_r[BIT_AW-1:0];
  assign mark_word = (mode_r == MODE_MARK_USED) ? (word_q | bit_oh) : (word_q & ~bit_oh);

  // ---------------------------------------------------------------------------
  // region walk: find the region of the allocated page and its offset there
  // ---------------------------------------------------------------------------
  always_comb begin
    walk_rem = page_r;
    walk_hit = 1'b0;
    walk_sel = '0;
    for (int r = 0; r < NUM_REGIONS; r++) begin
      if (!walk_hit && (2'(r) < n_use)) begin
        if (PAGES_W'(walk_rem) < pages_r[r]) begin
          walk_hit = 1'b1;
          walk_sel = 2'(r);
        end else begin
          // remainder is at least this region's count, so the count fits
          walk_rem = walk_rem - pages_r[r][PAGE_AW-1:0];
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // memory port control
  // ---------------------------------------------------------------------------
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = '0;
    wr_en   = 1'b0;
    wr_addr = chk_w_r;
    wr_data = word_q | iso;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_mode == MODE_ALLOC && total_w != '0) begin
            rd_en   = 1'b1;
            rd_addr = '0;
          end else if ((in_mode == MODE_MARK_USED || in_mode == MODE_MARK_FREE)
                       && in_range) begin
            rd_en   = 1'b1;
            rd_addr = in_req.page_index[PAGE_AW-1:BIT_AW];
          end
        end
      end
      ST_SCAN: begin
        if (any_free) begin
          // claim the lowest free page of this word
          wr_en   = 1'b1;
          wr_addr = chk_w_r;
          wr_data = word_q | iso;
        end else if (more) begin
          rd_en   = 1'b1;
          rd_addr = nxt_w_ext[WORD_AW-1:0];
        end
      end
      ST_MARK: begin
        wr_en   = 1'b1;
        wr_addr = page_r[PAGE_AW-1:BIT_AW];
        wr_data = mark_word;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rd_en) chk_w_r <= rd_addr;
  end

  // ---------------------------------------------------------------------------
  // sequencer and result register
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      out_vld_r <= 1'b0;
    end else begin
      // the hand-over state reloads the result register itself
      if (state_r != ST_DONE && out_vld_r && out_rsp.ready) out_vld_r <= 1'b0;
      unique case (state_r)
        ST_IDLE: begin
          if (in_acc) begin
            mode_r     <= in_mode;
            page_r     <= in_req.page_index;
            res_addr_r <= '0;
            unique case (in_mode)
              MODE_ALLOC: begin
                if (total_w != '0) begin
                  res_sts_r <= STS_OK;
                  state_r   <= ST_SCAN;
                end else begin
                  res_sts_r <= STS_OOM;
                  state_r   <= ST_DONE;
                end
              end
              MODE_MARK_USED, MODE_MARK_FREE: begin
                if (in_range) begin
                  res_sts_r <= STS_OK;
                  state_r   <= ST_MARK;
                end else begin
                  res_sts_r <= STS_RANGE;
                  state_r   <= ST_DONE;
                end
              end
              MODE_NONE: begin
                res_sts_r <= STS_OK;
                state_r   <= ST_DONE;
              end
            endcase
          end
        end
        ST_SCAN: begin
          if (any_free) begin
            page_r  <= {chk_w_r, free_idx};
            state_r <= ST_WALK;
          end else if (!more) begin
            res_sts_r <= STS_OOM;
            state_r   <= ST_DONE;
          end
        end
        ST_MARK: begin
          state_r <= ST_DONE;
        end
        ST_WALK: begin
          sel_r   <= walk_sel;
          hit_r   <= walk_hit;
          rem_r   <= walk_rem;
          state_r <= ST_ADD;
        end
        ST_ADD: begin
          // address wraps modulo 2^64
          res_addr_r <= hit_r ? base_r[sel_r] + (ADDR_W'(rem_r) << PAGE_SHIFT) : '0;
          res_sts_r  <= STS_OK;
          state_r    <= ST_DONE;
        end
        ST_DONE: begin
          if (!out_vld_r || out_rsp.ready) begin
            out_vld_r  <= 1'b1;
            out_addr_r <= res_addr_r;
            out_sts_r  <= res_sts_r;
            state_r    <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_rsp.valid   = out_vld_r;
  assign out_rsp.address = out_addr_r;
  assign out_rsp.status  = out_sts_r;

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------
  // a result appears only when the sequencer hands it over
  a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_vld_r) |-> $past(state_r == ST_DONE))
    else $error("result raised outside of the hand-over state");

  // the region walk only follows a successful scan
  a_walk_after_scan: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_WALK) |-> $past(state_r == ST_SCAN))
    else $error("region walk entered without a found page");

  // an allocation claims exactly one previously free page
  a_claim_one_bit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN && wr_en) |-> $onehot(wr_data ^ word_q))
    else $error("scan write-back changes other than one bit");

  // failed requests never carry an address
  a_error_no_addr: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && out_sts_r != STS_OK) |-> (out_addr_r == '0))
    else $error("error result with nonzero address");

endmodule
